// ----- sv/tfd_pkg.sv -----
// Package for the touch frame deframer: header, command and length constants,
// position widths, register indexes and the touch target codes.
// Depends on nothing; used by touch_frame_deframer.
`default_nettype none

package tfd_pkg;

   // Largest frame accepted, header and length byte included.
   localparam int MAX_FRAME_BYTES = 64;

   localparam logic [7:0] HDR_FIRST      = 8'h5A;
   localparam logic [7:0] HDR_SECOND     = 8'hA5;
   localparam logic [7:0] CMD_READ_REPLY = 8'h83;

   // A frame spans its length byte plus this many bytes.
   localparam int LEN_OVERHEAD = 3;
   localparam int MIN_FRAME    = 8;

   // Byte position within a frame stays below MAX_FRAME_BYTES.
   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   // Width for comparing positions against length plus overhead (up to 258).
   localparam int TOTAL_W = 9;
   localparam int CMP_W   = (POS_W > TOTAL_W) ? POS_W : TOTAL_W;

   localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SECOND  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_COMMAND = POS_W'(3);
   localparam logic [POS_W-1:0] POS_ADDR_HI = POS_W'(4);
   localparam logic [POS_W-1:0] POS_ADDR_LO = POS_W'(5);
   localparam logic [POS_W-1:0] POS_WORD_HI = POS_W'(6);
   localparam logic [POS_W-1:0] POS_WORD_LO = POS_W'(7);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MENU_ADDRESS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_ADDRESS      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANIMATION_ADDRESS = 2'd2;

   typedef enum logic [1:0] {
      TARGET_MENU      = 2'd0,
      TARGET_MODE      = 2'd1,
      TARGET_ANIMATION = 2'd2
   } target_type;

endpackage

`default_nettype wire

// ----- sv/touch_frame_deframer.sv -----
// Touch frame deframer: reassembles display frames from received bytes and
// reports touch events. Depends on tfd_pkg.
// Latency: a result word appears in rsp_* on the cycle after the final byte of
// its frame is accepted. Throughput: one byte word per cycle; req_ready only
// drops while a finished result is held and rsp_ready is low.
// Reset (synchronous, active high) returns to header hunt, clears addresses.
`default_nettype none

module touch_frame_deframer (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [7:0]                      req_rx_byte,

   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [1:0]                      rsp_touch_target,
   output      logic [15:0]                     rsp_touch_word,

   input  wire logic                            csr_we,
   input  wire logic [tfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tfd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tfd_pkg::*;

   // Configured touch addresses.
   logic [15:0] menu_addr_ff;
   logic [15:0] mode_addr_ff;
   logic [15:0] anim_addr_ff;

   // Frame state: position of the next byte and the captured fields.
   logic [POS_W-1:0] pos_ff,  pos_in;
   logic [7:0]       len_ff,  len_in;
   logic [7:0]       cmd_ff,  cmd_in;
   logic [15:0]      addr_ff, addr_in;
   logic [15:0]      word_ff, word_in;

   // Result register. It lets the next byte in only when empty or being drained.
   logic             rsp_valid_ff,  rsp_valid_in;
   target_type       rsp_target_ff, rsp_target_in;
   logic [15:0]      rsp_word_ff,   rsp_word_in;

   logic             accept;
   logic [POS_W-1:0] pos_inc;
   logic [CMP_W-1:0] total;

   // A byte is taken whenever the result register is empty or being drained.
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_touch_target = rsp_target_ff;
   assign rsp_touch_word   = rsp_word_ff;

   always_comb begin
      pos_in        = pos_ff;
      len_in        = len_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      word_in       = word_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_target_in = rsp_target_ff;
      rsp_word_in   = rsp_word_ff;
      pos_inc       = pos_ff + POS_W'(1);
      total         = CMP_W'(len_ff) + CMP_W'(LEN_OVERHEAD);

      if (accept) begin
         if (pos_ff == POS_HUNT) begin
            if (req_rx_byte == HDR_FIRST) begin
               pos_in = POS_SECOND;
            end
         end else if (pos_ff == POS_SECOND) begin
            // A bad second header byte is dropped; the hunt resumes after it.
            pos_in = (req_rx_byte == HDR_SECOND) ? POS_LENGTH : POS_HUNT;
         end else begin
            case (pos_ff)
               POS_LENGTH:  len_in        = req_rx_byte;
               POS_COMMAND: cmd_in        = req_rx_byte;
               POS_ADDR_HI: addr_in[15:8] = req_rx_byte;
               POS_ADDR_LO: addr_in[7:0]  = req_rx_byte;
               POS_WORD_HI: word_in[15:8] = req_rx_byte;
               POS_WORD_LO: word_in[7:0]  = req_rx_byte;
               default: ;
            endcase

            // The frame size uses the length byte as updated by this byte.
            total = CMP_W'(len_in) + CMP_W'(LEN_OVERHEAD);

            if (total > CMP_W'(MAX_FRAME_BYTES)) begin
               pos_in = POS_HUNT;
            end else if (CMP_W'(pos_inc) < total) begin
               pos_in = pos_inc;
            end else begin
               // Last byte of the frame: decide on a touch event.
               pos_in = POS_HUNT;
               if (total >= CMP_W'(MIN_FRAME) && cmd_in == CMD_READ_REPLY) begin
                  if (addr_in == menu_addr_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_target_in = TARGET_MENU;
                     rsp_word_in   = word_in;
                  end else if (addr_in == mode_addr_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_target_in = TARGET_MODE;
                     rsp_word_in   = word_in;
                  end else if (addr_in == anim_addr_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_target_in = TARGET_ANIMATION;
                     rsp_word_in   = word_in;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HUNT;
         len_ff       <= '0;
         cmd_ff       <= '0;
         addr_ff      <= '0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         cmd_ff       <= cmd_in;
         addr_ff      <= addr_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_target_ff <= rsp_target_in;
      rsp_word_ff   <= rsp_word_in;
   end

   // Configuration registers; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         menu_addr_ff <= '0;
         mode_addr_ff <= '0;
         anim_addr_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MENU_ADDRESS:      menu_addr_ff <= csr_wdata;
            CSR_MODE_ADDRESS:      mode_addr_ff <= csr_wdata;
            CSR_ANIMATION_ADDRESS: anim_addr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The byte position never runs past the largest frame.
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_FRAME_BYTES))
      else $error("byte position beyond maximum frame size");

   // A new result only follows an accepted byte.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result raised without an accepted byte");

   // While hunting, one byte can move the position at most to the second header byte.
   assert property (@(posedge clock) disable iff (reset)
      (accept && pos_ff == POS_HUNT) |=> (pos_ff == POS_HUNT || pos_ff == POS_SECOND))
      else $error("hunt left header search too early");

   // A pending result that is not taken blocks the input.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while result is stalled");

endmodule

`default_nettype wire
